// ===== src/hscs_pkg.sv =====
// Shared constants, types and hash helpers for the suffix collision search core.
`timescale 1ns / 1ps
package hscs_pkg;

  // Default sizes for the top level parameters
  localparam int unsigned CHARSET_SIZE_DEF = 62;
  localparam int unsigned PREFIX_LEN_DEF   = 8;
  localparam int unsigned TABLE_LEN        = 62;

  // Symbol string, first symbol in the top byte
  localparam logic [TABLE_LEN*8-1:0] CHARSET_STR =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVXYZ0123456789_";

  // Configuration register map
  localparam int unsigned PADDR_W  = 3;
  localparam logic        REG_SEED = 1'b0;
  localparam logic        REG_GOAL = 1'b1;

  // Hash stage output handed to the lanes and the emitter
  typedef struct packed {
    logic        valid;
    logic        bad;
    logic [31:0] h33;
  } hscs_hash_t;

  // Symbol at a constant position
  function automatic logic [7:0] charset_sym(input int unsigned k);
    return CHARSET_STR[(TABLE_LEN-1-k)*8 +: 8];
  endfunction

  // Symbol at a signal-chosen position; zero past the end
  function automatic logic [7:0] sym_lookup(input logic [5:0] idx);
    logic [7:0] r;
    r = '0;
    for (int unsigned k = 0; k < TABLE_LEN; k++) begin
      if (idx == 6'(k)) r = charset_sym(k);
    end
    return r;
  endfunction

  // Membership mask over all byte values for the first n symbols
  function automatic logic [255:0] sym_mask(input int unsigned n);
    logic [255:0] m;
    m = '0;
    for (int unsigned k = 0; k < n; k++) m[charset_sym(k)] = 1'b1;
    return m;
  endfunction

  // h * 33 as shift and add
  function automatic logic [31:0] mul33(input logic [31:0] h);
    return h + {h[26:0], 5'b0};
  endfunction

  // One hash step: h * 33 xor sign-extended byte
  function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] b);
    return mul33(h) ^ {{24{b[7]}}, b};
  endfunction

endpackage

// ===== src/hash_suffix_collision_search_core.sv =====
// Top level of the suffix collision search core: config registers, hash pipe, lanes, merge.
//
// Usage: each input item (prefix_bytes_i, first_index_i) is taken on in_valid_i & in_ready_o.
// The prefix bytes are hashed from seed_value one byte per stage, then every charset symbol
// is tried as second character in its own lane. Each lane reports whether the goal hash is
// reached with a charset symbol as closing byte. Hits leave on the output channel in charset
// order, one item per cycle while out_ready_i is set, the final one with last_o set; with no hit
// a single not-found item (found_o = 0, last_o = 1) leaves instead.
// Path: prefix stages, first symbol stage, multiply stage, merge stage, output register.
// Throughput: one input item per cycle while each item yields one result; an item with several
// hits holds the merge stage until its last is emitted, and the pipeline stalls behind it.
// When the receiver stalls, the output register holds its item and the pipeline stops
// once the merge stage cannot hand over; in_ready_o falls at that point.
// Reset clears all valid bits and both config registers (seed and goal read as zero).
// Config: APB writes seed_value (0x0), goal_hash (0x4) only when idle; user must ensure it.
`timescale 1ns / 1ps
module hash_suffix_collision_search_core #(
  parameter int unsigned CHARSET_SIZE = hscs_pkg::CHARSET_SIZE_DEF,
  parameter int unsigned PREFIX_LEN   = hscs_pkg::PREFIX_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hscs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [63:0]                  prefix_bytes_i,
  input  logic [5:0]                   first_index_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [7:0]                   second_char_o,
  output logic [7:0]                   final_char_o,
  output logic                         last_o
);
  import hscs_pkg::*;

  localparam int unsigned N_EFF = (CHARSET_SIZE > TABLE_LEN) ? TABLE_LEN : CHARSET_SIZE;

  logic [31:0]      seed_q, goal_q;
  logic             wr_en, en;
  hscs_hash_t       hash;
  logic [N_EFF-1:0] hits;

  // Config registers
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      goal_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SEED: seed_q <= pwdata;
        REG_GOAL: goal_q <= pwdata;
        default:  ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (paddr[2])
      REG_SEED: prdata = seed_q;
      REG_GOAL: prdata = goal_q;
      default:  prdata = '0;
    endcase
  end

  assign in_ready_o = en;

  hscs_hash_pipe #(
    .CHARSET_SIZE (CHARSET_SIZE),
    .PREFIX_LEN   (PREFIX_LEN)
  ) u_hash_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .in_valid_i     (in_valid_i),
    .prefix_bytes_i (prefix_bytes_i),
    .first_index_i  (first_index_i),
    .seed_i         (seed_q),
    .hash_o         (hash)
  );

  // One lane per charset symbol
  for (genvar g = 0; g < N_EFF; g++) begin : g_lane
    hscs_lane #(
      .LANE  (g),
      .N_EFF (N_EFF)
    ) u_lane (
      .h33_i  (hash.h33),
      .goal_i (goal_q),
      .hit_o  (hits[g])
    );
  end

  hscs_emit #(
    .N_LANES (N_EFF)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hash_i        (hash),
    .hit_i         (hits),
    .goal_lo_i     (goal_q[7:0]),
    .en_o          (en),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .second_char_o (second_char_o),
    .final_char_o  (final_char_o),
    .last_o        (last_o)
  );

endmodule

// ===== src/hscs_hash_pipe.sv =====
// Prefix hashing pipeline: one byte per stage, then the first symbol and the extra *33.
`timescale 1ns / 1ps
module hscs_hash_pipe #(
  parameter int unsigned CHARSET_SIZE = 62,
  parameter int unsigned PREFIX_LEN   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic [63:0]         prefix_bytes_i,
  input  logic [5:0]          first_index_i,
  input  logic [31:0]         seed_i,
  output hscs_pkg::hscs_hash_t hash_o
);
  import hscs_pkg::*;

  localparam int unsigned N_EFF = (CHARSET_SIZE > TABLE_LEN) ? TABLE_LEN : CHARSET_SIZE;

  // Prefix stages
  logic        pv_q [PREFIX_LEN];
  logic [31:0] ph_q [PREFIX_LEN];
  logic [63:0] pb_q [PREFIX_LEN];
  logic [5:0]  pf_q [PREFIX_LEN];
  logic        pbad_q [PREFIX_LEN];

  // First symbol stage and final multiply stage
  logic        fv_q, fbad_q, hv_q, hbad_q;
  logic [31:0] fh_q, hh_q;
  logic        in_bad;

  assign in_bad = {1'b0, first_index_i} >= 7'(N_EFF);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < PREFIX_LEN; k++) pv_q[k] <= 1'b0;
      fv_q <= 1'b0;
      hv_q <= 1'b0;
    end else if (en_i) begin
      pv_q[0] <= in_valid_i;
      for (int unsigned k = 1; k < PREFIX_LEN; k++) pv_q[k] <= pv_q[k-1];
      fv_q <= pv_q[PREFIX_LEN-1];
      hv_q <= fv_q;
    end
  end

  // Hash datapath, one byte per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q[0]   <= mix(seed_i, prefix_bytes_i[63:56]);
      pb_q[0]   <= {prefix_bytes_i[55:0], 8'h00};
      pf_q[0]   <= first_index_i;
      pbad_q[0] <= in_bad;
      for (int unsigned k = 1; k < PREFIX_LEN; k++) begin
        ph_q[k]   <= mix(ph_q[k-1], pb_q[k-1][63:56]);
        pb_q[k]   <= {pb_q[k-1][55:0], 8'h00};
        pf_q[k]   <= pf_q[k-1];
        pbad_q[k] <= pbad_q[k-1];
      end
      fh_q   <= mix(ph_q[PREFIX_LEN-1], sym_lookup(pf_q[PREFIX_LEN-1]));
      fbad_q <= pbad_q[PREFIX_LEN-1];
      hh_q   <= mul33(fh_q);
      hbad_q <= fbad_q;
    end
  end

  assign hash_o.valid = hv_q;
  assign hash_o.bad   = hbad_q;
  assign hash_o.h33   = hh_q;

endmodule

// ===== src/hscs_lane.sv =====
// One candidate lane: tries a fixed second symbol against the goal hash.
`timescale 1ns / 1ps
module hscs_lane #(
  parameter int unsigned LANE  = 0,
  parameter int unsigned N_EFF = 62
) (
  input  logic [31:0] h33_i,
  input  logic [31:0] goal_i,
  output logic        hit_o
);
  import hscs_pkg::*;

  localparam logic [7:0]   SYM      = charset_sym(LANE);
  localparam logic [255:0] SYM_MASK = sym_mask(N_EFF);

  logic [31:0] full, diff;

  // Full hash with this lane's symbol, then compare above the low byte
  assign full  = mul33(h33_i ^ {{24{SYM[7]}}, SYM});
  assign diff  = goal_i ^ full;
  assign hit_o = (diff[31:8] == 24'h0) && SYM_MASK[diff[7:0]];

endmodule

// ===== src/hscs_emit.sv =====
// Merge stage: collects lane hits and emits them in symbol order into the output register.
`timescale 1ns / 1ps
module hscs_emit #(
  parameter int unsigned N_LANES = 62
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hscs_pkg::hscs_hash_t hash_i,
  input  logic [N_LANES-1:0]   hit_i,
  input  logic [7:0]           goal_lo_i,
  output logic                 en_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [7:0]           second_char_o,
  output logic [7:0]           final_char_o,
  output logic                 last_o
);
  import hscs_pkg::*;

  localparam int unsigned IDX_W = (N_LANES > 1) ? $clog2(N_LANES) : 1;

  logic               em_valid_q, em_valid_d;
  logic [N_LANES-1:0] em_mask_q, em_mask_d;
  logic [7:0]         em_hlo_q, em_hlo_d;

  logic               out_valid_q, out_valid_d;
  logic               found_q, found_d, last_q, last_d;
  logic [7:0]         second_q, second_d, final_q, final_d;

  logic [N_LANES-1:0] low_bit, rest;
  logic [IDX_W-1:0]   idx;
  logic [7:0]         sym, mixed, fin;
  logic               slot_free, emit, em_last, any_hit;

  // Lowest pending hit and its symbol
  always_comb begin
    low_bit = em_mask_q & (~em_mask_q + N_LANES'(1));
    rest    = em_mask_q & ~low_bit;
    idx     = '0;
    for (int unsigned k = 0; k < N_LANES; k++) begin
      if (low_bit[k]) idx = idx | IDX_W'(k);
    end
  end

  assign sym     = sym_lookup(6'(idx));
  // Closing byte only needs the low byte of the hash
  assign mixed   = em_hlo_q ^ sym;
  assign fin     = goal_lo_i ^ (mixed + {mixed[2:0], 5'b0});
  assign any_hit = |em_mask_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = em_valid_q && slot_free;
  assign em_last   = (rest == '0);
  assign en_o      = !em_valid_q || (slot_free && em_last);

  // Pending item
  always_comb begin
    em_valid_d = em_valid_q;
    em_mask_d  = em_mask_q;
    em_hlo_d   = em_hlo_q;
    if (en_o) begin
      em_valid_d = hash_i.valid;
      em_mask_d  = hash_i.bad ? '0 : hit_i;
      em_hlo_d   = hash_i.h33[7:0];
    end else if (emit) begin
      em_mask_d  = rest;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    second_d    = second_q;
    final_d     = final_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      found_d     = any_hit;
      second_d    = any_hit ? sym : 8'h00;
      final_d     = any_hit ? fin : 8'h00;
      last_d      = em_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      em_valid_q  <= em_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    em_mask_q <= em_mask_d;
    em_hlo_q  <= em_hlo_d;
    found_q   <= found_d;
    second_q  <= second_d;
    final_q   <= final_d;
    last_q    <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign second_char_o = second_q;
  assign final_char_o  = final_q;
  assign last_o        = last_q;

endmodule
